// ----- rtl/hpoc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpoc_pkg
// Shared types, constants and a helper function for the picture order count
// derivation block.
// ----------------------------------------------------------------------------
package hpoc_pkg;

    localparam int LSB_W = 16;
    localparam int MSB_W = 32;
    localparam int IDX_W = 16;
    localparam int CFG_W = 5;
    localparam int NAL_W = 6;
    localparam int TID_W = 3;
    localparam int PSET_W = 4;

    localparam logic [CFG_W-1:0] LOG2_MIN = 5'd4;
    localparam logic [CFG_W-1:0] LOG2_MAX = 5'd16;
    localparam logic [CFG_W-1:0] LOG2_RESET = 5'd4;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    // NAL unit types that the derivation treats specially.
    localparam logic [NAL_W-1:0] NAL_RSV_VCL_N14 = 6'd14;
    localparam logic [NAL_W-1:0] NAL_RADL_N = 6'd6;
    localparam logic [NAL_W-1:0] NAL_RASL_R = 6'd9;
    localparam logic [NAL_W-1:0] NAL_BLA_W_LP = 6'd16;
    localparam logic [NAL_W-1:0] NAL_BLA_N_LP = 6'd18;
    localparam logic [NAL_W-1:0] NAL_IDR_W_RADL = 6'd19;
    localparam logic [NAL_W-1:0] NAL_IDR_N_LP = 6'd20;

    typedef struct packed {
        logic [NAL_W-1:0]  nal_type;
        logic [TID_W-1:0]  sublayer;
        logic [LSB_W-1:0]  poc_lsb;
        logic [PSET_W-1:0] param_set_index;
        logic              batch_start;
    } t_frame;

    typedef struct packed {
        logic signed [MSB_W-1:0] presentation_order;
        logic [IDX_W-1:0]        decode_order;
        logic                    order_valid;
        logic                    mixed_param_sets;
    } t_result;

    typedef struct packed {
        logic [LSB_W-1:0]  ref_lsb;
        logic [MSB_W-1:0]  ref_msb;
        logic [PSET_W-1:0] batch_param_set;
        logic              batch_stopped;
        logic [IDX_W-1:0]  frame_index;
    } t_state;

    // Sub-layer non-reference pictures, RADL and RASL never become the
    // previous reference picture.
    function automatic logic never_reference(input logic [NAL_W-1:0] nal_type);
        logic even_low;
        logic radl_rasl;
        even_low = (nal_type <= NAL_RSV_VCL_N14) && !nal_type[0];
        radl_rasl = (nal_type >= NAL_RADL_N) && (nal_type <= NAL_RASL_R);
        return even_low || radl_rasl;
    endfunction

endpackage

// ----- rtl/hpoc_frame_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpoc_frame_if
// Valid/ready channel that carries one coded frame descriptor.
// ----------------------------------------------------------------------------
interface hpoc_frame_if;
    logic                           valid;
    logic                           ready;
    logic [hpoc_pkg::NAL_W-1:0]     nal_type;
    logic [hpoc_pkg::TID_W-1:0]     sublayer;
    logic [hpoc_pkg::LSB_W-1:0]     poc_lsb;
    logic [hpoc_pkg::PSET_W-1:0]    param_set_index;
    logic                           batch_start;

    modport source (
        output valid, nal_type, sublayer, poc_lsb, param_set_index, batch_start,
        input  ready
    );
    modport sink (
        input  valid, nal_type, sublayer, poc_lsb, param_set_index, batch_start,
        output ready
    );
endinterface

// ----- rtl/hpoc_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpoc_result_if
// Valid/ready channel that carries one derived picture order result.
// ----------------------------------------------------------------------------
interface hpoc_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [hpoc_pkg::MSB_W-1:0]  presentation_order;
    logic [hpoc_pkg::IDX_W-1:0]         decode_order;
    logic                               order_valid;
    logic                               mixed_param_sets;

    modport source (
        output valid, presentation_order, decode_order, order_valid, mixed_param_sets,
        input  ready
    );
    modport sink (
        input  valid, presentation_order, decode_order, order_valid, mixed_param_sets,
        output ready
    );
endinterface

// ----- rtl/hpoc_calc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpoc_calc
// Combinational derivation of one frame's order and of the next state.
// ----------------------------------------------------------------------------
module hpoc_calc (
    input  hpoc_pkg::t_frame                  i_frame,
    input  hpoc_pkg::t_state                  i_state,
    input  logic [hpoc_pkg::CFG_W-1:0]        i_log2_max_poc_lsb,
    output hpoc_pkg::t_result                 o_result,
    output hpoc_pkg::t_state                  o_state
);

    logic [hpoc_pkg::PSET_W-1:0]  batch_pset;
    logic [hpoc_pkg::IDX_W-1:0]   index;
    logic                         stopped;
    logic [hpoc_pkg::CFG_W-1:0]   l2;
    logic [hpoc_pkg::LSB_W:0]     max_lsb;
    logic [hpoc_pkg::LSB_W:0]     half;
    logic [hpoc_pkg::LSB_W:0]     mask;
    logic [hpoc_pkg::LSB_W-1:0]   lsb;
    logic [hpoc_pkg::LSB_W:0]     diff_dn;
    logic [hpoc_pkg::LSB_W:0]     diff_up;
    logic                         wrap_up;
    logic                         wrap_dn;
    logic [hpoc_pkg::MSB_W-1:0]   max_ext;
    logic [hpoc_pkg::MSB_W-1:0]   msb;
    logic [hpoc_pkg::MSB_W-1:0]   order;
    logic                         is_idr;
    logic                         is_bla;
    logic                         updates_ref;

    always_comb begin
        // A batch start rebinds the batch before the parameter set check.
        batch_pset = i_frame.batch_start ? i_frame.param_set_index
                                         : i_state.batch_param_set;
        index      = i_frame.batch_start ? '0 : i_state.frame_index;
        stopped    = (!i_frame.batch_start && i_state.batch_stopped)
                     || (i_frame.param_set_index != batch_pset);

        if (i_log2_max_poc_lsb < hpoc_pkg::LOG2_MIN) begin
            l2 = hpoc_pkg::LOG2_MIN;
        end else if (i_log2_max_poc_lsb > hpoc_pkg::LOG2_MAX) begin
            l2 = hpoc_pkg::LOG2_MAX;
        end else begin
            l2 = i_log2_max_poc_lsb;
        end
        max_lsb = {{hpoc_pkg::LSB_W{1'b0}}, 1'b1} << l2;
        half    = max_lsb >> 1;
        mask    = max_lsb - {{hpoc_pkg::LSB_W{1'b0}}, 1'b1};
        lsb     = i_frame.poc_lsb & mask[hpoc_pkg::LSB_W-1:0];

        // Half-range wrap test against the previous reference LSB.
        diff_dn = {1'b0, i_state.ref_lsb} - {1'b0, lsb};
        diff_up = {1'b0, lsb} - {1'b0, i_state.ref_lsb};
        wrap_up = (lsb < i_state.ref_lsb) && (diff_dn >= half);
        wrap_dn = (lsb > i_state.ref_lsb) && (diff_up > half);
        max_ext = {{(hpoc_pkg::MSB_W-hpoc_pkg::LSB_W-1){1'b0}}, max_lsb};

        is_idr = (i_frame.nal_type == hpoc_pkg::NAL_IDR_W_RADL)
                 || (i_frame.nal_type == hpoc_pkg::NAL_IDR_N_LP);
        is_bla = (i_frame.nal_type >= hpoc_pkg::NAL_BLA_W_LP)
                 && (i_frame.nal_type <= hpoc_pkg::NAL_BLA_N_LP);

        if (is_bla) begin
            msb = '0;
        end else if (wrap_up) begin
            msb = i_state.ref_msb + max_ext;
        end else if (wrap_dn) begin
            msb = i_state.ref_msb - max_ext;
        end else begin
            msb = i_state.ref_msb;
        end
        order = is_idr ? '0
                       : ({{(hpoc_pkg::MSB_W-hpoc_pkg::LSB_W){1'b0}}, lsb} + msb);
        updates_ref = (i_frame.sublayer == '0)
                      && (is_idr || !hpoc_pkg::never_reference(i_frame.nal_type));

        o_state = i_state;
        if (stopped) begin
            // A stopped batch leaves everything but the stop flag alone.
            o_state.batch_stopped       = 1'b1;
            o_result.presentation_order = '0;
            o_result.decode_order       = '0;
            o_result.order_valid        = 1'b0;
            o_result.mixed_param_sets   = 1'b1;
        end else begin
            o_state.batch_param_set     = batch_pset;
            o_state.batch_stopped       = 1'b0;
            o_state.frame_index         = (index < hpoc_pkg::IDX_MAX)
                                          ? index + 1'b1 : index;
            if (updates_ref) begin
                o_state.ref_lsb = is_idr ? '0 : lsb;
                o_state.ref_msb = is_idr ? '0 : msb;
            end
            o_result.presentation_order = $signed(order);
            o_result.decode_order       = index;
            o_result.order_valid        = 1'b1;
            o_result.mixed_param_sets   = 1'b0;
        end
    end

endmodule

// ----- rtl/hevc_picture_order_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_picture_order_count
// Derives the picture order count and batch decode index of coded frames.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Carries
//   i_frame   in         valid / ready    NAL type, temporal id, POC LSB,
//                                         parameter set index, batch start
//   o_result  out        valid / ready    presentation order, decode order,
//                                         order valid, mixed parameter sets
//   i_cfg_*   in         write enable     log2_max_poc_lsb, 5 bits
//
// One frame per cycle is sustained unless the output stalls; the reference
// LSB/MSB and batch state update while the frame sits in the input register.
// The result register follows the input register on the way to the output.
// Reset (synchronous, active low) empties both registers, clears the state
// and sets log2_max_poc_lsb to 4. An output stall fills the result register,
// then the input register; after that i_frame.ready drops.
// ----------------------------------------------------------------------------
module hevc_picture_order_count (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    hpoc_frame_if.sink                   i_frame,
    hpoc_result_if.source                o_result,
    input  logic                         i_cfg_we,
    input  logic [hpoc_pkg::CFG_W-1:0]   i_cfg_wdata
);

    // Input stage: the accepted frame waits here for one derivation pass.
    logic                        r_in_valid;
    logic                        n_in_valid;
    hpoc_pkg::t_frame            r_in;

    // Result stage: the finished result waits here for its transfer.
    logic                        r_out_valid;
    logic                        n_out_valid;
    hpoc_pkg::t_result           r_out;

    // Reference and batch state carried from frame to frame.
    hpoc_pkg::t_state            r_state;
    hpoc_pkg::t_state            n_state;
    logic [hpoc_pkg::CFG_W-1:0]  r_log2_max_poc_lsb;

    hpoc_pkg::t_result           calc_result;
    hpoc_pkg::t_state            calc_state;
    logic                        in_xfer;
    logic                        advance;

    // The input stage moves on whenever the result register is free or
    // is being emptied in this very cycle.
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_frame.ready  = !r_in_valid || advance;
    assign in_xfer        = i_frame.valid && i_frame.ready;

    hpoc_calc u_calc (
        .i_frame            (r_in),
        .i_state            (r_state),
        .i_log2_max_poc_lsb (r_log2_max_poc_lsb),
        .o_result           (calc_result),
        .o_state            (calc_state)
    );

    always_comb begin
        n_in_valid  = in_xfer || (r_in_valid && !advance);
        n_out_valid = advance || (r_out_valid && !o_result.ready);
        // State only moves when a frame leaves the input stage, so the next
        // frame always sees the state left by its predecessor.
        n_state     = advance ? calc_state : r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_state            <= '0;
            r_log2_max_poc_lsb <= hpoc_pkg::LOG2_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_log2_max_poc_lsb <= i_cfg_wdata;
            end
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.nal_type        <= i_frame.nal_type;
            r_in.sublayer        <= i_frame.sublayer;
            r_in.poc_lsb         <= i_frame.poc_lsb;
            r_in.param_set_index <= i_frame.param_set_index;
            r_in.batch_start     <= i_frame.batch_start;
        end
        if (advance) begin
            r_out <= calc_result;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.presentation_order = r_out.presentation_order;
    assign o_result.decode_order       = r_out.decode_order;
    assign o_result.order_valid        = r_out.order_valid;
    assign o_result.mixed_param_sets   = r_out.mixed_param_sets;

endmodule

// ----- rtl/hpoc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpoc_checker
// Port-level assertions for the picture order count block.
// ----------------------------------------------------------------------------
module hpoc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [hpoc_pkg::MSB_W-1:0]  i_presentation_order,
    input logic [hpoc_pkg::IDX_W-1:0]         i_decode_order,
    input logic                               i_order_valid,
    input logic                               i_mixed_param_sets
);

    // The two status flags are always complementary on a result.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_order_valid != i_mixed_param_sets))
        else $error("order_valid and mixed_param_sets agree");

    // A stopped frame carries zero orders.
    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_order_valid) |->
            (i_presentation_order == '0 && i_decode_order == '0))
        else $error("stopped frame carries nonzero orders");

    // No result may appear right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_presentation_order)
             && $stable(i_decode_order) && $stable(i_order_valid)))
        else $error("stalled result changed");

endmodule

bind hevc_picture_order_count hpoc_checker u_hpoc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_result.valid),
    .i_out_ready          (o_result.ready),
    .i_presentation_order (o_result.presentation_order),
    .i_decode_order       (o_result.decode_order),
    .i_order_valid        (o_result.order_valid),
    .i_mixed_param_sets   (o_result.mixed_param_sets)
);

// ----- tb/poc_order_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poc_order_checker
// Watches the frame and result channels, predicts each frame's picture order
// result and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module poc_order_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    hpoc_frame_if                      i_frame,
    hpoc_result_if                     i_result,
    input  logic                       i_cfg_we,
    input  logic [hpoc_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_halted,
    output int                         o_saturated,
    output int                         o_negative
);
    import hpoc_pkg::*;

    localparam int REPORT_CAP = 100;

    // Predictor copy of the register and of the derivation state.
    logic [CFG_W-1:0]  lsb_log2;
    logic [LSB_W-1:0]  anchor_lsb;
    logic [MSB_W-1:0]  anchor_msb;
    logic [PSET_W-1:0] batch_pset;
    logic              batch_halted;
    logic [IDX_W-1:0]  batch_index;

    t_result expected_q[$];
    t_result predicted;
    t_result want;
    t_result got;
    t_frame  seen;

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_checked   = 0;
        o_halted    = 0;
        o_saturated = 0;
        o_negative  = 0;
    end

    // RADL, RASL and sub-layer non-reference types never become the anchor.
    function automatic logic skips_anchor(input logic [NAL_W-1:0] nal);
        if (nal >= NAL_RADL_N && nal <= NAL_RASL_R)
            return 1'b1;
        return (nal <= NAL_RSV_VCL_N14) ? ~nal[0] : 1'b0;
    endfunction

    task automatic derive_result(input t_frame f, output t_result r);
        logic [CFG_W-1:0] lsb_bits;
        logic [31:0]      span;
        logic [31:0]      half_span;
        logic [31:0]      lsb;
        logic [31:0]      msb;
        r = '0;
        if (f.batch_start) begin
            batch_index  = '0;
            batch_halted = 1'b0;
            batch_pset   = f.param_set_index;
        end
        if (f.param_set_index != batch_pset)
            batch_halted = 1'b1;
        if (batch_halted) begin
            r.mixed_param_sets = 1'b1;
            return;
        end
        lsb_bits = (lsb_log2 < LOG2_MIN) ? LOG2_MIN :
                   (lsb_log2 > LOG2_MAX) ? LOG2_MAX : lsb_log2;
        span      = 32'd1 << lsb_bits;
        half_span = span >> 1;
        if (f.nal_type == NAL_IDR_W_RADL || f.nal_type == NAL_IDR_N_LP) begin
            r.presentation_order = '0;
            if (f.sublayer == '0) begin
                anchor_lsb = '0;
                anchor_msb = '0;
            end
        end else begin
            lsb = {16'd0, f.poc_lsb} & (span - 32'd1);
            if (lsb < anchor_lsb && ({16'd0, anchor_lsb} - lsb) >= half_span)
                msb = anchor_msb + span;
            else if (lsb > anchor_lsb && (lsb - {16'd0, anchor_lsb}) > half_span)
                msb = anchor_msb - span;
            else
                msb = anchor_msb;
            if (f.nal_type >= NAL_BLA_W_LP && f.nal_type <= NAL_BLA_N_LP)
                msb = '0;
            r.presentation_order = lsb + msb;
            if (f.sublayer == '0 && !skips_anchor(f.nal_type)) begin
                anchor_lsb = lsb[LSB_W-1:0];
                anchor_msb = msb;
            end
        end
        r.decode_order = batch_index;
        r.order_valid  = 1'b1;
        if (batch_index != IDX_MAX)
            batch_index = batch_index + 1'b1;
    endtask

    task automatic report_mismatch(input string field, input longint exp_v,
                                   input longint act_v);
        if (o_errors < REPORT_CAP)
            $display("%0t poc_order_checker: %s expected %0d, actual %0d",
                     $time, field, exp_v, act_v);
        o_errors = o_errors + 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lsb_log2     = LOG2_RESET;
            anchor_lsb   = '0;
            anchor_msb   = '0;
            batch_pset   = '0;
            batch_halted = 1'b0;
            batch_index  = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_we)
                lsb_log2 = i_cfg_wdata;
            // Results leave only after their frame has passed the input and result
            // registers, so the comparison goes first and never sees this edge's prediction.
            if (i_result.valid && i_result.ready) begin
                got.presentation_order = i_result.presentation_order;
                got.decode_order       = i_result.decode_order;
                got.order_valid        = i_result.order_valid;
                got.mixed_param_sets   = i_result.mixed_param_sets;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result, presentation_order", 0,
                                    got.presentation_order);
                end else begin
                    want = expected_q.pop_front();
                    o_checked = o_checked + 1;
                    if (want.mixed_param_sets)
                        o_halted = o_halted + 1;
                    if (want.order_valid && want.decode_order == IDX_MAX)
                        o_saturated = o_saturated + 1;
                    if (want.presentation_order < 0)
                        o_negative = o_negative + 1;
                    if (got.presentation_order !== want.presentation_order)
                        report_mismatch("presentation_order", want.presentation_order,
                                        got.presentation_order);
                    if (got.decode_order !== want.decode_order)
                        report_mismatch("decode_order", want.decode_order,
                                        got.decode_order);
                    if (got.order_valid !== want.order_valid)
                        report_mismatch("order_valid", want.order_valid, got.order_valid);
                    if (got.mixed_param_sets !== want.mixed_param_sets)
                        report_mismatch("mixed_param_sets", want.mixed_param_sets,
                                        got.mixed_param_sets);
                end
            end
            if (i_frame.valid && i_frame.ready) begin
                seen.nal_type        = i_frame.nal_type;
                seen.sublayer        = i_frame.sublayer;
                seen.poc_lsb         = i_frame.poc_lsb;
                seen.param_set_index = i_frame.param_set_index;
                seen.batch_start     = i_frame.batch_start;
                derive_result(seen, predicted);
                expected_q = {expected_q, predicted};
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the picture order count block: a directed opening,
// then randomized batches over a range of LSB widths.
// ----------------------------------------------------------------------------
module tb_top;
    import hpoc_pkg::*;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 3;
    localparam int DRAIN_CYCLES     = 4;
    localparam int HOLD_CYCLES      = 300;      // long output stall
    localparam int LIMIT_CYCLES     = 1000000;
    localparam int RANDOM_PER_PHASE = 230;
    localparam int PLAN_SIZE        = 9;
    localparam int HOLD_PHASE       = 1;
    localparam int CALM_PHASE       = 3;        // neither side idles here

    // NAL unit types used only by the stimulus.
    localparam logic [NAL_W-1:0] NAL_TRAIL_N     = 6'd0;
    localparam logic [NAL_W-1:0] NAL_TRAIL_R     = 6'd1;
    localparam logic [NAL_W-1:0] NAL_TSA_N       = 6'd2;
    localparam logic [NAL_W-1:0] NAL_RADL_R      = 6'd7;
    localparam logic [NAL_W-1:0] NAL_RASL_N      = 6'd8;
    localparam logic [NAL_W-1:0] NAL_RSV_VCL_R15 = 6'd15;
    localparam logic [NAL_W-1:0] NAL_BLA_W_RADL  = 6'd17;
    localparam logic [NAL_W-1:0] NAL_CRA         = 6'd21;
    localparam logic [NAL_W-1:0] NAL_LAST_VCL    = 6'd21;
    localparam logic [NAL_W-1:0] NAL_VPS         = 6'd32;
    localparam logic [NAL_W-1:0] NAL_UNSPEC_63   = 6'd63;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    hpoc_frame_if  frame_ch ();
    hpoc_result_if result_ch ();

    // Checker outputs.
    int errors;
    int pending;
    int checked;
    int halted;
    int saturated;
    int negative;

    // Shared between the sender and the receiver. Both only change at the
    // falling edge, through nonblocking assignments.
    logic idle_on      = 1'b1;
    logic hold_request = 1'b0;
    int   hold_left;
    int   cycles = 0;

    // State of the random frame generator: it follows the stream so that most
    // frames land near the previous LSB and batches stay well formed.
    logic [LSB_W-1:0]  gen_lsb;
    logic [PSET_W-1:0] gen_pset;
    int                batch_left;
    logic [CFG_W-1:0]  lsb_plan [0:PLAN_SIZE-1];

    always #HALF_PERIOD clk = ~clk;

    hevc_picture_order_count dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_frame     (frame_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    poc_order_checker order_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_frame     (frame_ch),
        .i_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_halted    (halted),
        .o_saturated (saturated),
        .o_negative  (negative)
    );

    function automatic t_frame frame_of(input logic [NAL_W-1:0] nal,
                                        input logic [TID_W-1:0] tid,
                                        input logic [LSB_W-1:0] lsb,
                                        input logic [PSET_W-1:0] pset,
                                        input logic start);
        t_frame f;
        f.nal_type        = nal;
        f.sublayer        = tid;
        f.poc_lsb         = lsb;
        f.param_set_index = pset;
        f.batch_start     = start;
        return f;
    endfunction

    // Offers one frame and returns at the falling edge after its transfer.
    // Valid stays high on return, so back-to-back frames never toggle it
    // within one time step; it only drops inside an idle gap or a drain.
    task automatic send_frame(input t_frame f);
        while (idle_on && $urandom_range(99) < 10) begin
            frame_ch.valid <= 1'b0;
            @(negedge clk);
        end
        frame_ch.valid           <= 1'b1;
        frame_ch.nal_type        <= f.nal_type;
        frame_ch.sublayer        <= f.sublayer;
        frame_ch.poc_lsb         <= f.poc_lsb;
        frame_ch.param_set_index <= f.param_set_index;
        frame_ch.batch_start     <= f.batch_start;
        @(posedge clk);
        while (!frame_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Waits until every predicted result has been seen, then lets the
    // pipeline settle before the register may be touched.
    task automatic drain_results();
        frame_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic program_lsb_width(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Builds the next random frame.
    task automatic make_frame(output t_frame f);
        int pick;
        int stride;
        f = '0;
        if (batch_left == 0) begin
            f.batch_start = 1'b1;
            batch_left    = $urandom_range(1, 40);
            gen_pset      = 4'($urandom_range(0, 15));
        end
        batch_left = batch_left - 1;
        f.param_set_index = gen_pset;
        // A stray parameter set now and then halts the rest of the batch.
        if (!f.batch_start && $urandom_range(99) < 3)
            f.param_set_index = 4'($urandom_range(0, 15));

        pick = $urandom_range(99);
        if (pick < 6)
            f.nal_type = NAL_IDR_W_RADL;
        else if (pick < 10)
            f.nal_type = NAL_IDR_N_LP;
        else if (pick < 15)
            f.nal_type = 6'($urandom_range(NAL_BLA_W_LP, NAL_BLA_N_LP));
        else if (pick < 55)
            f.nal_type = NAL_TRAIL_R;
        else if (pick < 80)
            f.nal_type = 6'($urandom_range(0, NAL_LAST_VCL));
        else
            f.nal_type = 6'($urandom_range(0, 63));

        f.sublayer = ($urandom_range(99) < 55) ? 3'd0 : 3'($urandom_range(1, 6));

        if (f.nal_type == NAL_IDR_W_RADL || f.nal_type == NAL_IDR_N_LP) begin
            // IDR frames normally carry a zero LSB; a few carry junk.
            f.poc_lsb = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 65535)) : 16'd0;
            gen_lsb   = '0;
        end else begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                // Strides of every scale, mostly forward, so that wraps in
                // both directions occur at every LSB width.
                stride = $urandom_range(0, (1 << $urandom_range(1, 16)) - 1);
                if ($urandom_range(99) < 70)
                    gen_lsb = gen_lsb + 16'(stride);
                else
                    gen_lsb = gen_lsb - 16'(stride);
            end else if (pick < 90) begin
                gen_lsb = 16'($urandom_range(0, 65535));
            end else begin
                gen_lsb = $urandom_range(1) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                            : 16'($urandom_range(0, 3));
            end
            f.poc_lsb = gen_lsb;
        end
    endtask

    // Output side: random idling, plus one long hold-off on request so that
    // the result register and then the input register fill and the frame
    // channel stalls.
    initial begin
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request && hold_left == 0) begin
                hold_left     = HOLD_CYCLES;
                hold_request <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left        = hold_left - 1;
                result_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(99) < 10) begin
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that is still going long past the slowest correct
    // schedule is taken as hung.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb_top: no progress after %0d cycles, %0d results outstanding",
                     cycles, pending);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        t_frame f;
        int     phase;
        int     n;

        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_wdata                = '0;
        frame_ch.valid           = 1'b0;
        frame_ch.nal_type        = '0;
        frame_ch.sublayer        = '0;
        frame_ch.poc_lsb         = '0;
        frame_ch.param_set_index = '0;
        frame_ch.batch_start     = 1'b0;
        gen_lsb                  = '0;
        gen_pset                 = '0;
        batch_left               = 0;
        lsb_plan = '{5'd16, 5'd0, 5'd31, 5'd8, 5'd12, 5'd3, 5'd17, 5'd4, 5'd10};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening at the reset LSB width of 4 bits, where the LSB
        // range is 16 and half of it is 8.
        // A batch on set 3 starts with an IDR frame: order 0, index 0.
        send_frame(frame_of(NAL_IDR_W_RADL, 3'd0, 16'd0, 4'd3, 1'b1));
        send_frame(frame_of(NAL_TRAIL_R, 3'd0, 16'd5, 4'd3, 1'b0));
        // A jump forward by more than half the range takes the MSB below
        // zero, so the order goes negative and the MSB wraps at 32 bits.
        send_frame(frame_of(NAL_TRAIL_R, 3'd0, 16'd15, 4'd3, 1'b0));
        // Dropping back by at least half the range brings the MSB up again.
        send_frame(frame_of(NAL_TRAIL_R, 3'd0, 16'd2, 4'd3, 1'b0));
        // Non-reference types must leave the anchor alone.
        send_frame(frame_of(NAL_TRAIL_N, 3'd0, 16'd12, 4'd3, 1'b0));
        send_frame(frame_of(NAL_RADL_N, 3'd0, 16'd7, 4'd3, 1'b0));
        send_frame(frame_of(NAL_RADL_R, 3'd0, 16'd11, 4'd3, 1'b0));
        send_frame(frame_of(NAL_RASL_N, 3'd0, 16'd13, 4'd3, 1'b0));
        send_frame(frame_of(NAL_RASL_R, 3'd0, 16'd1, 4'd3, 1'b0));
        send_frame(frame_of(NAL_TSA_N, 3'd0, 16'd14, 4'd3, 1'b0));
        send_frame(frame_of(NAL_RSV_VCL_N14, 3'd0, 16'd10, 4'd3, 1'b0));
        // An odd type above the sub-layer range does become the anchor.
        send_frame(frame_of(NAL_RSV_VCL_R15, 3'd0, 16'd12, 4'd3, 1'b0));
        // BLA frames force the MSB to zero; a wide LSB is masked.
        send_frame(frame_of(NAL_BLA_W_LP, 3'd0, 16'd9, 4'd3, 1'b0));
        send_frame(frame_of(NAL_BLA_W_RADL, 3'd1, 16'd3, 4'd3, 1'b0));
        send_frame(frame_of(NAL_BLA_N_LP, 3'd0, 16'hFFFF, 4'd3, 1'b0));
        // An IDR frame on a higher sub-layer gets order 0 but no anchor reset.
        send_frame(frame_of(NAL_IDR_N_LP, 3'd2, 16'hABCD, 4'd3, 1'b0));
        // Unspecified and non-VCL types go through the ordinary path.
        send_frame(frame_of(NAL_UNSPEC_63, 3'd6, 16'h8000, 4'd3, 1'b0));
        send_frame(frame_of(NAL_VPS, 3'd5, 16'h0005, 4'd3, 1'b0));
        // A foreign parameter set halts the batch; the rest of it stays halted
        // even on the right set.
        send_frame(frame_of(NAL_TRAIL_R, 3'd0, 16'd4, 4'd4, 1'b0));
        send_frame(frame_of(NAL_IDR_W_RADL, 3'd0, 16'd0, 4'd3, 1'b0));
        // New batches on sets 15 and 0 clear the halt and the index.
        send_frame(frame_of(NAL_TRAIL_R, 3'd0, 16'd4, 4'd15, 1'b1));
        send_frame(frame_of(NAL_TRAIL_R, 3'd0, 16'h5555, 4'd15, 1'b0));
        send_frame(frame_of(NAL_TRAIL_R, 3'd4, 16'hAAAA, 4'd15, 1'b0));
        send_frame(frame_of(NAL_CRA, 3'd3, 16'd6, 4'd15, 1'b0));
        send_frame(frame_of(NAL_TRAIL_R, 3'd0, 16'd0, 4'd0, 1'b1));
        // The sender waits here until every expected result has come.
        drain_results();

        // Random phases, one LSB width each, including writes below and
        // above the legal range. One phase carries the long output stall
        // and another runs with no idling on either side.
        for (phase = 0; phase < PLAN_SIZE; phase++) begin
            program_lsb_width(lsb_plan[phase]);
            idle_on <= (phase != CALM_PHASE);
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (phase == HOLD_PHASE && n == 40)
                    hold_request <= 1'b1;
                make_frame(f);
                send_frame(f);
            end
            drain_results();
        end

        $display("tb_top: %0d results compared, %0d from halted batches, %0d negative orders,",
                 checked, halted, negative);
        $display("tb_top: %0d at the decode index ceiling, LSB widths 4 to 16 bits, %0d mismatches",
                 saturated, errors);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hpoc_pkg.sv
rtl/hpoc_frame_if.sv
rtl/hpoc_result_if.sv
rtl/hpoc_calc.sv
rtl/hevc_picture_order_count.sv
rtl/hpoc_checker.sv
tb/poc_order_checker.sv
tb/tb_top.sv
